// ===== hdl/escape_time_orbit_pow15_unit_defines.svh =====
// Assertion macros for the escape-time orbit unit
`ifndef ESCAPE_TIME_ORBIT_POW15_UNIT_DEFINES_SVH
`define ESCAPE_TIME_ORBIT_POW15_UNIT_DEFINES_SVH
// Same-cycle implication, sampled on clk, off during reset
`define ETOP_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define ETOP_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/etop_pkg.sv =====
// Shared types, constants and helpers for the escape-time orbit unit
package etop_pkg;
	localparam int FRAC_BITS = 28;
	localparam int DW = 32;

	typedef struct packed {
		logic [DW-1:0] start_imag;
		logic [DW-1:0] start_real;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic [1:0] count;
	} queue_stat_t;

	// floor(acc / 2^28) + c, clamped to the signed 32-bit range
	function automatic logic [DW-1:0] sat_add(input logic signed [64:0] acc,
			input logic signed [DW-1:0] c);
		logic signed [64:0] t;
		t = (acc >>> FRAC_BITS) + 65'(c);
		if (t > 65'sh0_7FFF_FFFF)
			return 32'h7FFF_FFFF;
		else if (t < -65'sh0_8000_0000)
			return 32'h8000_0000;
		else
			return t[DW-1:0];
	endfunction
endpackage

// ===== hdl/escape_time_orbit_pow15_unit.sv =====
// Top level of the escape-time orbit unit for z <- z^1.5 + k
//   Channel | Direction | Carries
//   s_*     | in        | one start point per transaction
//   m_*     | out       | one orbit point per transaction, tlast on the final one
//   cfg_*   | in        | register writes: 0 const_real, 1 const_imag, 2 iteration_limit
// Each non-final orbit point runs three serial square roots, which dominate, plus
// the multiplies, escape test, emit and update. The final point needs only the
// multiplies, escape test and emit. One start point is worked at a time.
// Reset is asynchronous and needs no clearing pass. A two-entry input queue keeps
// accepting while the back end works, until both entries are full; a held output
// stalls the sequencer only when the next point is ready to go out.
`include "escape_time_orbit_pow15_unit_defines.svh"
module escape_time_orbit_pow15_unit #(
	parameter int MAX_ITERATIONS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // start_real, start_imag
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // point_real, point_imag
	output logic        m_tuser,   // escaped
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import etop_pkg::*;

	localparam logic [1:0] REG_CONST_REAL = 2'd0;
	localparam logic [1:0] REG_CONST_IMAG = 2'd1;
	localparam logic [1:0] REG_ITER_LIMIT = 2'd2;

	logic [31:0] const_real_q, const_imag_q;
	logic [6:0]  iter_limit_q;
	logic        q_valid, q_pop;
	item_t       q_item;
	queue_stat_t q_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			const_real_q <= 32'hFCCC_CCCD;
			const_imag_q <= '0;
			iter_limit_q <= 7'd64;
		end else if (cfg_we) begin
			if (cfg_index == REG_CONST_REAL)
				const_real_q <= cfg_wdata;
			else if (cfg_index == REG_CONST_IMAG)
				const_imag_q <= cfg_wdata;
			else if (cfg_index == REG_ITER_LIMIT)
				iter_limit_q <= cfg_wdata[6:0];
		end
	end

	etop_in_queue u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_tdata),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.q_stat   (q_stat)
	);

	etop_orbit #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_item          (q_item),
		.const_real      (const_real_q),
		.const_imag      (const_imag_q),
		.iteration_limit (iter_limit_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast)
	);

	`ETOP_ASSERT_IMP(a_esc_is_last, m_tvalid && m_tuser, m_tlast, "escaped point not marked last")
	`ETOP_ASSERT_IMP(a_queue_bound, 1'b1, q_stat.count != 2'd3, "input queue overfilled")
	`ETOP_ASSERT_NXT(a_pop_frees, q_stat.count == 2'd2 && q_pop, s_tready, "pop did not free a slot")
endmodule

// ===== hdl/etop_in_queue.sv =====
// Front end: two-entry queue of start points
module etop_in_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  etop_pkg::item_t      s_item,
	output logic                 q_valid,
	input  logic                 q_pop,
	output etop_pkg::item_t      q_item,
	output etop_pkg::queue_stat_t q_stat
);
	import etop_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;
	assign q_stat.count = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= s_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hdl/etop_isqrt.sv =====
// Iterative 64-bit integer square root, one root bit per cycle
module etop_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  etop_pkg::sqrt_req_t req,
	output logic                done,
	output logic [31:0]         root
);
	import etop_pkg::*;

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [32:0] rem_q;
	logic [31:0] root_q;
	logic [34:0] rem_sh, trial, diff;
	logic        ge;

	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);
	assign diff   = rem_sh - trial;
	assign done   = done_q;
	assign root   = root_q;

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (ge) begin
				rem_q  <= diff[32:0];
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[32:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== hdl/etop_orbit.sv =====
// Back end: orbit sequencer with shared multiplier, square root and output register
module etop_orbit #(
	parameter int MAX_ITERATIONS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  etop_pkg::item_t     q_item,
	input  logic [31:0]         const_real,
	input  logic [31:0]         const_imag,
	input  logic [6:0]          iteration_limit,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [63:0]         m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);
	import etop_pkg::*;

	typedef enum logic [3:0] {
		IDLE, M_XX, M_YY, M_SUM, EMIT, SQ_R, SQ_A, SQ_B,
		P_XA, P_YB, P_XB, P_YA, P_ACC, UPD
	} state_t;

	localparam logic [64:0] ESC_LIM = 65'd1 << (2 * FRAC_BITS + 2);

	state_t             st_q;
	logic signed [31:0] x_q, y_q, a_q, b_q, nx_q, r_q;
	logic signed [64:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] opa, opb;
	logic [6:0]         lim_q, n_q, lim_eff;
	logic               out_free, esc, fin;
	sqrt_req_t          sreq;
	logic               sdone;
	logic [31:0]        sroot;
	logic [63:0]        rx_sum, rx_dif;

	etop_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.done   (sdone),
		.root   (sroot)
	);

	assign lim_eff = (iteration_limit == 7'd0) ? 7'd1 :
		(iteration_limit > 7'(MAX_ITERATIONS)) ? 7'(MAX_ITERATIONS) : iteration_limit;
	assign out_free = !m_tvalid || m_tready;
	assign esc      = (acc_q > $signed(ESC_LIM));
	assign fin      = esc || (n_q + 7'd1 == lim_q);
	assign q_pop    = (st_q == IDLE) && q_valid;

	// operands of the shared multiplier
	always_comb begin
		opa = x_q;
		opb = x_q;
		unique case (st_q)
			M_YY:    begin opa = y_q; opb = y_q; end
			P_XA:    begin opa = x_q; opb = a_q; end
			P_YB:    begin opa = y_q; opb = b_q; end
			P_XB:    begin opa = x_q; opb = b_q; end
			P_YA:    begin opa = y_q; opb = a_q; end
			default: begin opa = x_q; opb = x_q; end
		endcase
	end

	// square root requests: |z|^2, then (r + x) << 27, then (r - x) << 27
	assign rx_sum = {32'd0, sroot} + {{32{x_q[31]}}, x_q};
	assign rx_dif = {{32{r_q[31]}}, r_q} - {{32{x_q[31]}}, x_q};
	always_comb begin
		sreq.start    = 1'b0;
		sreq.radicand = acc_q[63:0];
		if (st_q == EMIT) begin
			sreq.start = out_free && !fin;
		end else if (st_q == SQ_R) begin
			sreq.start    = sdone;
			sreq.radicand = rx_sum << (FRAC_BITS - 1);
		end else if (st_q == SQ_A) begin
			sreq.start    = sdone;
			sreq.radicand = rx_dif << (FRAC_BITS - 1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		unique case (st_q)
			IDLE: begin
				x_q   <= q_item.start_real;
				y_q   <= q_item.start_imag;
				lim_q <= lim_eff;
			end
			M_YY, P_YB: acc_q <= 65'(prod_q);
			M_SUM, P_ACC: acc_q <= acc_q + 65'(prod_q);
			P_XB: acc_q <= acc_q - 65'(prod_q);
			P_YA: begin
				nx_q  <= sat_add(acc_q, const_real);
				acc_q <= 65'(prod_q);
			end
			SQ_R: if (sdone) r_q <= sroot;
			SQ_A: if (sdone) a_q <= sroot;
			SQ_B: if (sdone) b_q <= y_q[31] ? -sroot : sroot;
			UPD: begin
				x_q <= nx_q;
				y_q <= sat_add(acc_q, const_imag);
			end
			default: ;
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= IDLE;
			n_q      <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
			m_tlast  <= 1'b0;
		end else begin
			if (m_tready && !(st_q == EMIT && out_free))
				m_tvalid <= 1'b0;
			unique case (st_q)
				IDLE: if (q_valid) begin
					n_q  <= '0;
					st_q <= M_XX;
				end
				M_XX:  st_q <= M_YY;
				M_YY:  st_q <= M_SUM;
				M_SUM: st_q <= EMIT;
				EMIT: if (out_free) begin
					m_tvalid <= 1'b1;
					m_tdata  <= {y_q, x_q};
					m_tuser  <= esc;
					m_tlast  <= fin;
					st_q     <= fin ? IDLE : SQ_R;
				end
				SQ_R: if (sdone) st_q <= SQ_A;
				SQ_A: if (sdone) st_q <= SQ_B;
				SQ_B: if (sdone) st_q <= P_XA;
				P_XA:  st_q <= P_YB;
				P_YB:  st_q <= P_XB;
				P_XB:  st_q <= P_YA;
				P_YA:  st_q <= P_ACC;
				P_ACC: st_q <= UPD;
				UPD: begin
					n_q  <= n_q + 7'd1;
					st_q <= M_XX;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the escape-time orbit unit z <- z^1.5 + k
`timescale 1ns / 100ps
module tb;
	localparam int LIMIT_CAP = 64;
	localparam int IDLE_LIMIT = 30000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 4000;
	localparam logic [1:0] REG_CONST_REAL = 2'd0;
	localparam logic [1:0] REG_CONST_IMAG = 2'd1;
	localparam logic [1:0] REG_ITER_LIMIT = 2'd2;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic signed [31:0] Q_ONE = 32'sd268435456;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               escaped;
		logic               last;
	} orbit_point_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // start_real, start_imag
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // point_real, point_imag
	logic        m_tuser;   // escaped
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	escape_time_orbit_pow15_unit dut (.*);

	// Predictor copy of the registers
	longint k_real;
	longint k_imag;
	int     iter_limit;

	logic [63:0]  start_queue[$];
	orbit_point_t orbit_expected[$];
	int  failures = 0;
	int  starts_sent = 0;
	int  points_seen = 0;
	int  src_gap = 0;
	int  sink_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 0;
	bit  calm = 0;
	int  idle_cycles = 0;

	// Clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > longint'(Q_MAX)) return longint'(Q_MAX);
		if (v < longint'(Q_MIN)) return longint'(Q_MIN);
		return v;
	endfunction

	// Append one start point to the pending list
	function automatic void add_start(logic [63:0] v);
		start_queue.insert(start_queue.size(), v);
	endfunction

	// Walk one orbit and queue every point it emits
	function automatic void orbit_predict(logic [63:0] start);
		longint x;
		longint y;
		longint nx;
		longint unsigned mx;
		longint unsigned my;
		longint unsigned r2;
		longint r;
		longint a;
		longint b;
		int lim;
		bit esc;
		bit fin;
		orbit_point_t p;
		x = longint'($signed(start[31:0]));
		y = longint'($signed(start[63:32]));
		lim = iter_limit < 1 ? 1 : (iter_limit > LIMIT_CAP ? LIMIT_CAP : iter_limit);
		for (int n = 0; n < lim; n++) begin
			mx = x < 0 ? -x : x;
			my = y < 0 ? -y : y;
			r2 = mx * mx + my * my;
			esc = r2 > (64'd4 << 56);
			fin = esc || (n + 1 == lim);
			p.re = x[31:0];
			p.im = y[31:0];
			p.escaped = esc;
			p.last = fin;
			orbit_expected.insert(orbit_expected.size(), p);
			if (fin) break;
			r = int_sqrt(r2);
			a = int_sqrt(longint'(r + x) << 27);
			b = int_sqrt(longint'(r - x) << 27);
			if (y < 0) b = -b;
			nx = clamp32(((x * a - y * b) >>> 28) + k_real);
			y = clamp32(((x * b + y * a) >>> 28) + k_imag);
			x = nx;
		end
	endfunction

	// Input driver: offers queued start points with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				orbit_predict(s_tdata);
				starts_sent++;
				if (!calm && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 10);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (start_queue.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= start_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: random back-pressure, one long hold, field compare
	always @(posedge clk or negedge arst_n) begin
		orbit_point_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				points_seen++;
				if (orbit_expected.size() == 0) begin
					$error("unexpected orbit point %h", m_tdata);
					failures++;
				end else begin
					e = orbit_expected.pop_front();
					if (m_tdata[31:0] !== e.re) begin
						$error("point_real expected %h actual %h", e.re, m_tdata[31:0]);
						failures++;
					end
					if (m_tdata[63:32] !== e.im) begin
						$error("point_imag expected %h actual %h", e.im, m_tdata[63:32]);
						failures++;
					end
					if (m_tuser !== e.escaped) begin
						$error("escaped expected %b actual %b", e.escaped, m_tuser);
						failures++;
					end
					if (m_tlast !== e.last) begin
						$error("last expected %b actual %b", e.last, m_tlast);
						failures++;
					end
				end
				if (!hold_done && points_seen == 60) begin
					hold_done = 1;
					hold_left = HOLD_CYCLES;
				end else if (!calm && $urandom_range(0, 4) == 0) begin
					sink_gap = $urandom_range(1, 10);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_CONST_REAL: k_real = longint'($signed(val));
			REG_CONST_IMAG: k_imag = longint'($signed(val));
			REG_ITER_LIMIT: iter_limit = val[6:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender holds until every queued start is done and all points are back
	task automatic drain();
		while (start_queue.size() > 0 || s_tvalid || orbit_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] pack_start(logic [31:0] re, logic [31:0] im);
		return {im, re};
	endfunction

	// Mostly inside the square of half-width three around the origin, sometimes anywhere
	function automatic logic [63:0] random_start();
		logic [31:0] re;
		logic [31:0] im;
		if ($urandom_range(0, 4) == 0) begin
			re = $urandom;
			im = $urandom;
		end else begin
			re = $signed($urandom_range(0, 32'd805306368 * 2)) - 32'sd805306368;
			im = $signed($urandom_range(0, 32'd805306368 * 2)) - 32'sd805306368;
		end
		return pack_start(re, im);
	endfunction

	initial begin
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		k_real = -53687091;
		k_imag = 0;
		iter_limit = LIMIT_CAP;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: extremes, exact radius two, negative real axis
		add_start(pack_start(0, 0));
		add_start(pack_start(Q_MAX, Q_MAX));
		add_start(pack_start(Q_MIN, Q_MIN));
		add_start(pack_start(Q_MIN, 0));
		add_start(pack_start(0, Q_MIN));
		add_start(pack_start(-Q_ONE, 0));
		add_start(pack_start(Q_ONE * 2, 0));
		add_start(pack_start(Q_ONE * 2, 1));
		add_start(pack_start(32'sd80530636, 32'sd134217728));
		add_start(pack_start(32'sd53687091, -32'sd107374182));
		add_start(pack_start(Q_ONE, -1));
		drain();

		// Saturating constant, unused register index
		write_reg(REG_CONST_REAL, Q_MAX);
		write_reg(REG_CONST_IMAG, Q_MIN);
		write_reg(REG_ITER_LIMIT, 32'd4);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		add_start(pack_start(Q_ONE, Q_ONE));
		add_start(pack_start(-Q_ONE, -Q_ONE));
		add_start(pack_start(0, 0));
		add_start(pack_start(-Q_ONE, 0));
		drain();

		// Zero limit acts as one, oversized limit acts as the cap
		write_reg(REG_CONST_REAL, Q_MIN);
		write_reg(REG_CONST_IMAG, Q_MAX);
		write_reg(REG_ITER_LIMIT, 32'd0);
		add_start(pack_start(Q_ONE, 0));
		add_start(pack_start(0, -Q_ONE));
		drain();
		write_reg(REG_CONST_REAL, 32'sd26843545);
		write_reg(REG_CONST_IMAG, -32'sd26843545);
		write_reg(REG_ITER_LIMIT, 32'd127);
		add_start(pack_start(0, 0));
		add_start(pack_start(32'sd134217728, 0));
		add_start(pack_start(-32'sd134217728, 32'sd53687091));
		drain();

		// Random phases with random settings; the last one runs without gaps
		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 5);
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_CONST_REAL, $urandom);
				write_reg(REG_CONST_IMAG, $urandom);
			end else begin
				write_reg(REG_CONST_REAL, $signed($urandom_range(0, 32'd268435456)) - 32'sd134217728);
				write_reg(REG_CONST_IMAG, $signed($urandom_range(0, 32'd268435456)) - 32'sd134217728);
			end
			write_reg(REG_ITER_LIMIT, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
				: $urandom_range(1, 24));
			for (int i = 0; i < 22; i++) add_start(random_start());
			drain();
		end

		$display("tb: %0d start points driven, %0d orbit points checked, %0d mismatches",
			starts_sent, points_seen, failures);
		$display("tb: covered extreme constants, limit clamping, saturation and long back-pressure");
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
